// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the response parser.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define ASSERT_IMPL(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/core/hrcp_pkg.sv =====
// Types and constants for the chunked HTTP response parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hrcp_pkg;
  localparam int LengthLimit  = 8192;
  localparam int MaxHexDigits = 6;
  localparam int BodyMax      = 65535;

  localparam logic [1:0] KIND_BODY   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [1:0] HDR_NONE = 2'd0;
  localparam logic [1:0] HDR_LEN  = 2'd1;
  localparam logic [1:0] HDR_TE   = 2'd2;
  localparam logic [1:0] HDR_CE   = 2'd3;

  typedef enum logic [13:0] {
    PH_PREFIX      = 14'b00000000000001,
    PH_STATUS_REST = 14'b00000000000010,
    PH_NAME        = 14'b00000000000100,
    PH_VALUE       = 14'b00000000001000,
    PH_PLAIN       = 14'b00000000010000,
    PH_CSIZE       = 14'b00000000100000,
    PH_CSIZE_LF    = 14'b00000001000000,
    PH_CDATA       = 14'b00000010000000,
    PH_DATA_CR     = 14'b00000100000000,
    PH_DATA_LF     = 14'b00001000000000,
    PH_TRAIL_CR    = 14'b00010000000000,
    PH_TRAIL_LF    = 14'b00100000000000,
    PH_DONE        = 14'b01000000000000,
    PH_ERROR       = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  body_byte;
    logic [9:0]  status_code;
    logic [15:0] body_length;
    logic        is_last;
  } out_word_t;

  function automatic logic [7:0] lower(input logic [7:0] b);
    lower = (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
  endfunction

  function automatic logic [7:0] status_char(input logic [3:0] i);
    unique case (i)
      4'd0: status_char = "H";
      4'd1, 4'd2: status_char = "T";
      4'd3: status_char = "P";
      4'd4: status_char = "/";
      4'd5, 4'd7: status_char = "1";
      4'd6: status_char = ".";
      default: status_char = " ";
    endcase
  endfunction

  // Name table lookup; q selects the header, index beyond the name reads as zero
  function automatic logic [7:0] name_char(input logic [1:0] q, input logic [4:0] i);
    logic [8*17-1:0] s;
    logic [4:0] n;
    unique case (q)
      HDR_LEN: begin s = {"content-length", 24'h0}; n = 5'd14; end
      HDR_TE:  begin s = "transfer-encoding"; n = 5'd17; end
      default: begin s = {"content-encoding", 8'h0}; n = 5'd16; end
    endcase
    if (i >= n) name_char = 8'h00;
    else name_char = s[8*(16-i) +: 8];
  endfunction

  function automatic logic [4:0] name_len(input logic [1:0] q);
    unique case (q)
      HDR_LEN: name_len = 5'd14;
      HDR_TE:  name_len = 5'd17;
      default: name_len = 5'd16;
    endcase
  endfunction

  function automatic logic [7:0] value_char(input logic [1:0] q, input logic [3:0] i);
    logic [63:0] s;
    if (q == HDR_TE) s = {"chunked", 8'h0};
    else s = "identity";
    value_char = (i >= 4'd8) ? 8'h00 : s[8*(7-i) +: 8];
  endfunction

  function automatic logic [3:0] value_len(input logic [1:0] q);
    value_len = (q == HDR_TE) ? 4'd7 : 4'd8;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/hrcp_stream_if.sv =====
// Valid/ready stream interface carrying one payload word.
// Payload types are the hrcp_pkg structs.
`timescale 1ns / 1ps
`default_nettype none
interface hrcp_in_if;
  logic valid;
  logic ready;
  hrcp_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hrcp_out_if;
  logic valid;
  logic ready;
  hrcp_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/http_response_chunked_parser.sv =====
// Chunked HTTP response parser: one byte word in, up to two result words out.
// The first result word of a byte is registered and presented in the cycle after the byte is accepted.
// Throughput: one byte per cycle while the output is taken; a byte that yields both
// a body word and the verdict fills the two-entry output queue and holds the input until it has room.
// Synchronous reset returns the parser to the status line start with the queue empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module http_response_chunked_parser (
  input  wire logic   clk,
  input  wire logic   rst,
  hrcp_in_if.sink     in_ch,
  hrcp_out_if.source  out_ch
);
  hrcp_pkg::phase_t phase, ph;
  logic [4:0]  line_position, lp;
  logic [9:0]  status_value, sv;
  logic        pending_cr, pcr;
  logic [2:0]  cand, cd;
  logic [1:0]  matched, mh;
  logic [3:0]  value_position, vp;
  logic        vf_started, vf_trailing, vf_bad, vs, vt, vb;
  logic [13:0] declared_length, dl;
  logic        seen_len, seen_te, sl, st;
  logic [13:0] chunk_remaining, cr;
  logic [2:0]  hex_count, hc;
  logic [15:0] body_count, bc;
  logic [4:0]  total_count, tc;

  // two-entry output queue
  hrcp_pkg::out_word_t q0, q1;
  logic [1:0] q_count;
  logic       emit_body, emit_final;
  hrcp_pkg::out_word_t body_word, final_word;
  logic       take, pop;

  logic [7:0] b;
  logic       eom;
  assign b   = in_ch.data.data_byte;
  assign eom = in_ch.data.end_of_message;
  assign in_ch.ready  = (q_count == 2'd0) || (q_count == 2'd1 && pop);
  assign take   = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (q_count != 2'd0);
  assign out_ch.data  = q0;

  always_comb begin
    logic [7:0] c;
    logic       redo, do_char, bad;
    logic [3:0] hx;
    logic       ok;
    logic [4:0] nlen;
    ph = phase; lp = line_position; sv = status_value; pcr = pending_cr;
    cd = cand; mh = matched; vp = value_position;
    vs = vf_started; vt = vf_trailing; vb = vf_bad;
    dl = declared_length; sl = seen_len; st = seen_te;
    cr = chunk_remaining; hc = hex_count; bc = body_count;
    tc = (total_count < 5'd31) ? total_count + 5'd1 : total_count;
    emit_body = 1'b0;
    c = b; redo = 1'b0; do_char = 1'b0; hx = 4'd0; ok = 1'b0; bad = 1'b0; nlen = '0;
    unique case (phase)
      hrcp_pkg::PH_PREFIX: begin
        if (line_position < 5'd9) begin
          if (b != hrcp_pkg::status_char(line_position[3:0])) ph = hrcp_pkg::PH_ERROR;
        end else if (line_position <= 5'd11) begin
          if (b < "0" || b > "9" || (line_position == 5'd9 && (b < "1" || b > "5")))
            ph = hrcp_pkg::PH_ERROR;
          else sv = 10'((status_value * 10) + 10'(b - "0"));
        end else begin
          if (b != " ") ph = hrcp_pkg::PH_ERROR;
          else ph = hrcp_pkg::PH_STATUS_REST;
        end
        lp = line_position + 5'd1;
      end
      hrcp_pkg::PH_STATUS_REST, hrcp_pkg::PH_NAME, hrcp_pkg::PH_VALUE: begin
        if (pending_cr) begin
          pcr = 1'b0;
          if (b == 8'h0a) begin
            // line end
            if (phase == hrcp_pkg::PH_STATUS_REST) begin
              ph = hrcp_pkg::PH_NAME; lp = '0; cd = 3'b111; mh = hrcp_pkg::HDR_NONE;
            end else if (phase == hrcp_pkg::PH_VALUE) begin
              if (matched == hrcp_pkg::HDR_LEN && !vf_started) ph = hrcp_pkg::PH_ERROR;
              else if (matched[1] && (vf_bad || value_position <
                       hrcp_pkg::value_len(matched))) ph = hrcp_pkg::PH_ERROR;
              else begin
                ph = hrcp_pkg::PH_NAME; lp = '0; cd = 3'b111; mh = hrcp_pkg::HDR_NONE;
              end
            end else if (line_position != 5'd0) ph = hrcp_pkg::PH_ERROR;
            else if (seen_len && seen_te) ph = hrcp_pkg::PH_ERROR;
            else if (seen_te) begin
              ph = hrcp_pkg::PH_CSIZE; cr = '0; hc = '0;
            end else ph = hrcp_pkg::PH_PLAIN;
          end else begin
            redo = 1'b1;
          end
        end else if (b == 8'h0d) pcr = 1'b1;
        else do_char = 1'b1;
      end
      hrcp_pkg::PH_PLAIN: begin
        if (body_count >= 16'(hrcp_pkg::BodyMax)) ph = hrcp_pkg::PH_ERROR;
        else begin bc = body_count + 16'd1; emit_body = 1'b1; end
      end
      hrcp_pkg::PH_CSIZE: begin
        if (b == 8'h0d) ph = (hex_count != 3'd0) ? hrcp_pkg::PH_CSIZE_LF : hrcp_pkg::PH_ERROR;
        else begin
          if (b >= "0" && b <= "9") hx = 4'(b - "0");
          else if (b >= "a" && b <= "f") hx = 4'(b - "a" + 8'd10);
          else if (b >= "A" && b <= "F") hx = 4'(b - "A" + 8'd10);
          else bad = 1'b1;
          if (bad) ph = hrcp_pkg::PH_ERROR;
          else if (hex_count >= 3'(hrcp_pkg::MaxHexDigits) ||
                   chunk_remaining > 14'(hrcp_pkg::LengthLimit / 16)) ph = hrcp_pkg::PH_ERROR;
          else begin
            hc = hex_count + 3'd1;
            cr = {chunk_remaining[9:0], hx};
          end
        end
      end
      hrcp_pkg::PH_CSIZE_LF: begin
        if (b != 8'h0a) ph = hrcp_pkg::PH_ERROR;
        else ph = (chunk_remaining != '0) ? hrcp_pkg::PH_CDATA : hrcp_pkg::PH_TRAIL_CR;
      end
      hrcp_pkg::PH_CDATA: begin
        if (body_count >= 16'(hrcp_pkg::BodyMax)) ph = hrcp_pkg::PH_ERROR;
        else begin
          bc = body_count + 16'd1; emit_body = 1'b1;
          cr = chunk_remaining - 14'd1;
          if (chunk_remaining == 14'd1) ph = hrcp_pkg::PH_DATA_CR;
        end
      end
      hrcp_pkg::PH_DATA_CR: ph = (b == 8'h0d) ? hrcp_pkg::PH_DATA_LF : hrcp_pkg::PH_ERROR;
      hrcp_pkg::PH_DATA_LF: begin
        if (b != 8'h0a) ph = hrcp_pkg::PH_ERROR;
        else begin ph = hrcp_pkg::PH_CSIZE; cr = '0; hc = '0; end
      end
      hrcp_pkg::PH_TRAIL_CR: ph = (b == 8'h0d) ? hrcp_pkg::PH_TRAIL_LF : hrcp_pkg::PH_ERROR;
      hrcp_pkg::PH_TRAIL_LF: ph = (b == 8'h0a) ? hrcp_pkg::PH_DONE : hrcp_pkg::PH_ERROR;
      default: ph = hrcp_pkg::PH_ERROR;
    endcase

    // A held CR is replayed as a line character, then the current byte follows unless it is a CR, which is held again.
    // Two line characters in one byte: apply them in sequence.
    for (int k = 0; k < 2; k++) begin
      if ((k == 0 && redo) || (k == 1 && (do_char || (redo && b != 8'h0d)))) begin
        c = (k == 0) ? 8'h0d : b;
        if (ph == hrcp_pkg::PH_NAME) begin
          if (c == ":") begin
            mh = hrcp_pkg::HDR_NONE;
            for (int q = 0; q < 3; q++) begin
              nlen = hrcp_pkg::name_len(2'(q + 1));
              if (cd[q] && lp == nlen) mh = 2'(q + 1);
            end
            if (mh == hrcp_pkg::HDR_LEN && sl) ph = hrcp_pkg::PH_ERROR;
            else if (mh == hrcp_pkg::HDR_TE && st) ph = hrcp_pkg::PH_ERROR;
            else begin
              if (mh == hrcp_pkg::HDR_LEN) sl = 1'b1;
              if (mh == hrcp_pkg::HDR_TE) st = 1'b1;
              vp = '0; vs = 1'b0; vt = 1'b0; vb = 1'b0;
              ph = hrcp_pkg::PH_VALUE;
            end
          end else begin
            for (int q = 0; q < 3; q++) begin
              nlen = hrcp_pkg::name_len(2'(q + 1));
              if (lp >= nlen || hrcp_pkg::lower(c) != hrcp_pkg::name_char(2'(q + 1), lp))
                cd[q] = 1'b0;
            end
            if (lp < 5'd31) lp = lp + 5'd1;
          end
        end else if (ph == hrcp_pkg::PH_VALUE && mh != hrcp_pkg::HDR_NONE &&
                     (vs || !(c == " " || c == 8'h09))) begin
          if (mh == hrcp_pkg::HDR_LEN) begin
            if (c == " " || c == 8'h09) vt = 1'b1;
            else if (vt || c < "0" || c > "9" || dl > 14'(hrcp_pkg::LengthLimit / 10))
              ph = hrcp_pkg::PH_ERROR;
            else begin
              dl = 14'((dl * 10) + 14'(c - "0"));
              vs = 1'b1;
            end
          end else begin
            vs = 1'b1;
            if (c == " " || c == 8'h09) begin
              if (vp < hrcp_pkg::value_len(mh)) vb = 1'b1;
            end else if (vp >= hrcp_pkg::value_len(mh) ||
                         hrcp_pkg::lower(c) != hrcp_pkg::value_char(mh, vp)) vb = 1'b1;
            if (vp < 4'd15) vp = vp + 4'd1;
          end
        end
      end
    end
    if (redo && b == 8'h0d && ph != hrcp_pkg::PH_ERROR) pcr = 1'b1;

    ok = (tc >= 5'd16);
    if (ph == hrcp_pkg::PH_PLAIN) begin
      if (sl && {2'b00, dl} != bc) ok = 1'b0;
    end else if (ph != hrcp_pkg::PH_DONE) ok = 1'b0;
    emit_final = eom;
    body_word = '{result_kind: hrcp_pkg::KIND_BODY, body_byte: b, status_code: '0,
                  body_length: '0, is_last: 1'b0};
    if (ok) final_word = '{result_kind: hrcp_pkg::KIND_ACCEPT, body_byte: '0,
                           status_code: sv, body_length: bc, is_last: 1'b1};
    else final_word = '{result_kind: hrcp_pkg::KIND_REJECT, body_byte: '0,
                        status_code: '0, body_length: '0, is_last: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst || (take && eom)) begin
      phase <= hrcp_pkg::PH_PREFIX; line_position <= '0; status_value <= '0;
      pending_cr <= 1'b0; cand <= 3'b111; matched <= hrcp_pkg::HDR_NONE;
      value_position <= '0; vf_started <= 1'b0; vf_trailing <= 1'b0; vf_bad <= 1'b0;
      declared_length <= '0; seen_len <= 1'b0; seen_te <= 1'b0;
      chunk_remaining <= '0; hex_count <= '0; body_count <= '0; total_count <= '0;
    end else if (take) begin
      phase <= ph; line_position <= lp; status_value <= sv; pending_cr <= pcr;
      cand <= cd; matched <= mh; value_position <= vp;
      vf_started <= vs; vf_trailing <= vt; vf_bad <= vb;
      declared_length <= dl; seen_len <= sl; seen_te <= st;
      chunk_remaining <= cr; hex_count <= hc; body_count <= bc; total_count <= tc;
    end
  end

  // output queue: q0 is the head
  always_ff @(posedge clk) begin
    logic [1:0] n;
    hrcp_pkg::out_word_t a0, a1;
    if (rst) begin
      q_count <= '0;
    end else begin
      a0 = q0; a1 = q1; n = q_count;
      if (pop) begin a0 = a1; n = n - 2'd1; end
      if (take && emit_body) begin
        if (n == 2'd0) a0 = body_word; else a1 = body_word;
        n = n + 2'd1;
      end
      if (take && emit_final) begin
        if (n == 2'd0) a0 = final_word; else a1 = final_word;
        n = n + 2'd1;
      end
      q0 <= a0; q1 <= a1; q_count <= n;
    end
  end

  `ASSERT_IMPL(a_count_range, clk, rst, 1'b1, q_count <= 2'd2)
  `ASSERT_IMPL(a_no_overflow, clk, rst, take, q_count == 2'd0 || (q_count == 2'd1 && pop))
  `ASSERT_NEXT(a_eom_resets, clk, rst, take && eom, phase == hrcp_pkg::PH_PREFIX)
  `ASSERT_IMPL(a_body_not_last, clk, rst,
               out_ch.valid && out_ch.data.result_kind == hrcp_pkg::KIND_BODY,
               !out_ch.data.is_last)
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the chunked HTTP response parser: feeds byte words, predicts every
// body word and verdict, and compares them with what the parser emits.
// Depends on hrcp_pkg, the stream interfaces and http_response_chunked_parser.
`timescale 1ns / 1ps
module testbench;
  import hrcp_pkg::*;

  localparam int ItemTarget = 1800;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 20;

  logic clk;
  logic rst;
  hrcp_in_if  in_ch ();
  hrcp_out_if out_ch ();

  http_response_chunked_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  typedef struct {
    string      text;
    logic [1:0] verdict;
    int         status;
    int         length;
  } directed_row_t;

  out_word_t   expected_words[$];
  out_word_t   last_verdict;
  byte unsigned msg_bytes[$];
  int          fail_count;
  int          items_sent;
  bit          stimulus_done;
  longint      cycle_count;

  // Parser shadow state
  phase_t      ph;
  int          lpos, stat, vpos, dlen, crem, hexn, bcnt, tcnt;
  bit          pend_cr;
  logic [2:0]  cand, vflags;
  logic [1:0]  hdr, seen;

  string status_head  = "HTTP/1.1 ";
  string hdr_names[3] = '{"content-length", "transfer-encoding", "content-encoding"};
  int    hdr_lens[3]  = '{14, 17, 16};

  function automatic int fold_case(int b);
    return (b >= "A" && b <= "Z") ? b + 32 : b;
  endfunction

  function automatic bit blank(int b);
    return b == " " || b == "\t";
  endfunction

  function automatic int expected_value_char(logic [1:0] h, int i);
    string s;
    s = (h == HDR_TE) ? "chunked" : "identity";
    return (i < s.len()) ? s[i] : 0;
  endfunction

  function automatic int value_len(logic [1:0] h);
    return (h == HDR_TE) ? 7 : 8;
  endfunction

  task automatic clear_parser();
    ph = PH_PREFIX; lpos = 0; stat = 0; pend_cr = 0; cand = 3'b111; hdr = HDR_NONE;
    vpos = 0; vflags = 0; dlen = 0; seen = 0; crem = 0; hexn = 0; bcnt = 0; tcnt = 0;
  endtask

  task automatic push_word(logic [1:0] k, int b, int st, int len, bit last);
    out_word_t w;
    w.result_kind = k; w.body_byte = b[7:0]; w.status_code = st[9:0];
    w.body_length = len[15:0]; w.is_last = last;
    expected_words.push_back(w);
    if (last) last_verdict = w;
  endtask

  task automatic begin_header_line();
    ph = PH_NAME; lpos = 0; cand = 3'b111; hdr = HDR_NONE;
  endtask

  task automatic header_name_byte(int b);
    if (b == ":") begin
      hdr = HDR_NONE;
      for (int q = 0; q < 3; q++)
        if (cand[q] && lpos == hdr_lens[q]) hdr = 2'(q + 1);
      if (hdr == HDR_LEN) begin
        if (seen[0]) begin ph = PH_ERROR; return; end
        seen[0] = 1;
      end else if (hdr == HDR_TE) begin
        if (seen[1]) begin ph = PH_ERROR; return; end
        seen[1] = 1;
      end
      vpos = 0; vflags = 0; ph = PH_VALUE;
      return;
    end
    for (int q = 0; q < 3; q++)
      if (lpos >= hdr_lens[q] || fold_case(b) != hdr_names[q][lpos]) cand[q] = 0;
    if (lpos < 31) lpos++;
  endtask

  task automatic header_value_byte(int b);
    if (hdr == HDR_NONE) return;
    if (!vflags[0] && blank(b)) return;
    if (hdr == HDR_LEN) begin
      if (blank(b)) begin vflags[1] = 1; return; end
      if (vflags[1] || b < "0" || b > "9" || dlen > LengthLimit / 10) begin
        ph = PH_ERROR; return;
      end
      dlen = dlen * 10 + (b - "0");
      vflags[0] = 1;
      return;
    end
    vflags[0] = 1;
    if (blank(b)) begin
      if (vpos < value_len(hdr)) vflags[2] = 1;
    end else if (vpos >= value_len(hdr) || fold_case(b) != expected_value_char(hdr, vpos)) begin
      vflags[2] = 1;
    end
    if (vpos < 15) vpos++;
  endtask

  task automatic line_byte(int b);
    if (ph == PH_NAME) header_name_byte(b);
    else if (ph == PH_VALUE) header_value_byte(b);
  endtask

  task automatic end_of_line();
    if (ph == PH_STATUS_REST) begin begin_header_line(); return; end
    if (ph == PH_VALUE) begin
      if (hdr == HDR_LEN && !vflags[0]) begin ph = PH_ERROR; return; end
      if (hdr >= HDR_TE && (vflags[2] || vpos < value_len(hdr))) begin
        ph = PH_ERROR; return;
      end
      begin_header_line();
      return;
    end
    if (lpos != 0 || seen == 2'b11) begin ph = PH_ERROR; return; end
    if (seen[1]) begin
      ph = PH_CSIZE; crem = 0; hexn = 0;
    end else begin
      ph = PH_PLAIN;
    end
  endtask

  task automatic emit_body(int b);
    if (bcnt >= BodyMax) begin ph = PH_ERROR; return; end
    bcnt++;
    push_word(KIND_BODY, b, 0, 0, 0);
  endtask

  task automatic parse_byte(int b);
    int hx;
    case (ph)
      PH_PREFIX: begin
        if (lpos < 9) begin
          if (b != status_head[lpos]) begin ph = PH_ERROR; return; end
        end else if (lpos <= 11) begin
          if (b < "0" || b > "9" || (lpos == 9 && (b < "1" || b > "5"))) begin
            ph = PH_ERROR; return;
          end
          stat = stat * 10 + (b - "0");
        end else begin
          if (b != " ") begin ph = PH_ERROR; return; end
          ph = PH_STATUS_REST;
        end
        lpos++;
      end
      PH_STATUS_REST, PH_NAME, PH_VALUE: begin
        if (pend_cr) begin
          pend_cr = 0;
          if (b == "\n") begin end_of_line(); return; end
          // lone CR is an ordinary line byte
          line_byte("\r");
          if (ph == PH_ERROR) return;
        end
        if (b == "\r") begin pend_cr = 1; return; end
        line_byte(b);
      end
      PH_PLAIN: emit_body(b);
      PH_CSIZE: begin
        if (b == "\r") begin
          ph = (hexn != 0) ? PH_CSIZE_LF : PH_ERROR;
          return;
        end
        if (b >= "0" && b <= "9") hx = b - "0";
        else if (b >= "a" && b <= "f") hx = b - "a" + 10;
        else if (b >= "A" && b <= "F") hx = b - "A" + 10;
        else begin ph = PH_ERROR; return; end
        hexn++;
        if (hexn > MaxHexDigits || crem > LengthLimit / 16) begin ph = PH_ERROR; return; end
        crem = crem * 16 + hx;
      end
      PH_CSIZE_LF: begin
        if (b != "\n") begin ph = PH_ERROR; return; end
        ph = (crem != 0) ? PH_CDATA : PH_TRAIL_CR;
      end
      PH_CDATA: begin
        emit_body(b);
        if (ph == PH_ERROR) return;
        crem--;
        if (crem == 0) ph = PH_DATA_CR;
      end
      PH_DATA_CR: ph = (b == "\r") ? PH_DATA_LF : PH_ERROR;
      PH_DATA_LF: begin
        if (b != "\n") begin ph = PH_ERROR; return; end
        ph = PH_CSIZE; crem = 0; hexn = 0;
      end
      PH_TRAIL_CR: ph = (b == "\r") ? PH_TRAIL_LF : PH_ERROR;
      PH_TRAIL_LF: ph = (b == "\n") ? PH_DONE : PH_ERROR;
      default: ph = PH_ERROR;
    endcase
  endtask

  task automatic predict_word(in_word_t w);
    bit ok;
    if (tcnt < 31) tcnt++;
    parse_byte(w.data_byte);
    if (w.end_of_message) begin
      ok = tcnt >= 16;
      if (ph == PH_PLAIN) begin
        if (seen[0] && dlen != bcnt) ok = 0;
      end else if (ph != PH_DONE) begin
        ok = 0;
      end
      if (ok) push_word(KIND_ACCEPT, 0, stat, bcnt, 1);
      else push_word(KIND_REJECT, 0, 0, 0, 1);
      clear_parser();
    end
  endtask

  // Message generation
  function automatic string mixed_case(string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 32;
    return r;
  endfunction

  function automatic string pad();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return "\t";
      2: return " \t ";
      default: return "";
    endcase
  endfunction

  task automatic append_text(string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  task automatic build_message();
    string  s;
    int     n, mode, chunked, pos;
    msg_bytes.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      n = $urandom_range(1, 40);
      repeat (n) msg_bytes.push_back($urandom_range(0, 255));
      return;
    end
    s = $sformatf("HTTP/1.1 %0d%0d%0d ", $urandom_range(1, 5), $urandom_range(0, 9),
                  $urandom_range(0, 9));
    repeat ($urandom_range(0, 4)) s = {s, ($urandom_range(0, 5) == 0) ? "\r" : "k"};
    s = {s, "\r\n"};
    repeat ($urandom_range(0, 2)) s = {s, mixed_case("x-note"), ":", pad(), "v\r\n"};
    if ($urandom_range(0, 3) == 0) s = {s, mixed_case("content-encoding"), ":", pad(),
                                        mixed_case("identity"), pad(), "\r\n"};
    chunked = $urandom_range(0, 1);
    n = $urandom_range(0, 24);
    if (chunked) begin
      s = {s, mixed_case("transfer-encoding"), ":", pad(), mixed_case("chunked"), pad(), "\r\n"};
    end else if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 15) == 0) s = {s, "Content-Length: 99999\r\n"};
      else s = {s, mixed_case("content-length"), ":", pad(), $sformatf("%0d", n), pad(), "\r\n"};
    end
    s = {s, "\r\n"};
    append_text(s);
    if (chunked) begin
      repeat ($urandom_range(0, 3)) begin
        n = $urandom_range(1, 12);
        append_text($urandom_range(0, 1) ? $sformatf("%0x\r\n", n) : $sformatf("%0X\r\n", n));
        repeat (n) msg_bytes.push_back($urandom_range(0, 255));
        append_text("\r\n");
      end
      append_text("0\r\n\r\n");
    end else begin
      repeat (n) msg_bytes.push_back($urandom_range(0, 255));
    end
    // corrupt some messages: overwrite, truncate or extend
    if ($urandom_range(0, 9) < 3) begin
      pos = $urandom_range(0, msg_bytes.size() - 1);
      case ($urandom_range(0, 2))
        0: msg_bytes[pos] = $urandom_range(0, 255);
        1: while (msg_bytes.size() > pos + 1) void'(msg_bytes.pop_back());
        default: msg_bytes.push_back($urandom_range(0, 255));
      endcase
    end
  endtask

  // Sender: bursts of random length with gaps between them
  int burst_left;

  task automatic send_message();
    in_word_t w;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 40);
      end
      w.data_byte      = msg_bytes[i];
      w.end_of_message = (i == msg_bytes.size() - 1);
      in_ch.valid <= 1'b1;
      in_ch.data  <= w;
      do @(posedge clk); while (!in_ch.ready);
      predict_word(w);
      items_sent++;
      burst_left--;
      @(negedge clk);
    end
  endtask

  directed_row_t directed[3] = '{
    '{"HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\nabc", KIND_ACCEPT, 200, 3},
    '{"HTTP/1.1 100 \r\n", KIND_REJECT, 0, 0},
    '{"HTTP/1.1 599 \r\ntransfer-encoding:chunked\r\n\r\n1\r\n\377\r\n0\r\n\r\n",
      KIND_ACCEPT, 599, 1}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    fail_count = 0;
    items_sent = 0;
    burst_left = 0;
    stimulus_done = 0;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[r]) begin
      msg_bytes.delete();
      append_text(directed[r].text);
      send_message();
      if (last_verdict.result_kind != directed[r].verdict ||
          last_verdict.status_code != directed[r].status[9:0] ||
          last_verdict.body_length != directed[r].length[15:0]) begin
        $error("directed row %0d: verdict expected %0d/%0d/%0d, predicted %0d/%0d/%0d", r,
               directed[r].verdict, directed[r].status, directed[r].length,
               last_verdict.result_kind, last_verdict.status_code, last_verdict.body_length);
        fail_count++;
      end
    end
    while (items_sent < ItemTarget) begin
      build_message();
      send_message();
    end
    in_ch.valid <= 1'b0;
    stimulus_done = 1;
  end

  // Receiver: own stall pattern, plus one long hold-off to back up the input
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (cycle_count == 1000) hold = 300;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if ((cycle_count / 200) % 3 == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word kind %0d", out_ch.data.result_kind);
        fail_count++;
      end else begin
        e = expected_words.pop_front();
        if (out_ch.data.result_kind !== e.result_kind) begin
          $error("result_kind expected %0d actual %0d", e.result_kind, out_ch.data.result_kind);
          fail_count++;
        end
        if (out_ch.data.body_byte !== e.body_byte) begin
          $error("body_byte expected %0d actual %0d", e.body_byte, out_ch.data.body_byte);
          fail_count++;
        end
        if (out_ch.data.status_code !== e.status_code) begin
          $error("status_code expected %0d actual %0d", e.status_code, out_ch.data.status_code);
          fail_count++;
        end
        if (out_ch.data.body_length !== e.body_length) begin
          $error("body_length expected %0d actual %0d", e.body_length, out_ch.data.body_length);
          fail_count++;
        end
        if (out_ch.data.is_last !== e.is_last) begin
          $error("is_last expected %0d actual %0d", e.is_last, out_ch.data.is_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    wait (stimulus_done);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
